>>> hw/rtl/ual_pkg.sv
// ----------------------------------------------------------------------------
// ual_pkg
// Shared constants for the unique address list: field widths, operation
// codes and the default list depth.
// ----------------------------------------------------------------------------
package ual_pkg;

	localparam int KEY_W           = 32;
	localparam int MODE_W          = 2;
	localparam int COUNT_W         = 6;
	localparam int MAX_ENTRIES_DEF = 32;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

endpackage

>>> hw/rtl/ual_if.sv
// ----------------------------------------------------------------------------
// ual_req_if / ual_rsp_if
// Valid/ready channels for the unique address list: operation requests in,
// one response per request out.
// ----------------------------------------------------------------------------
interface ual_req_if;
	logic                        valid;
	logic                        ready;
	logic [ual_pkg::MODE_W-1:0]  mode;
	logic [ual_pkg::KEY_W-1:0]   key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

interface ual_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic                        overwrote_last;
	logic [ual_pkg::COUNT_W-1:0] count;

	modport source (output valid, output found, output overwrote_last, output count,
		input ready);
	modport sink   (input valid, input found, input overwrote_last, input count,
		output ready);
endinterface

>>> hw/rtl/unique_address_list_top.sv
// ----------------------------------------------------------------------------
// unique_address_list_top
// Packed, ordered list of unique 32-bit addresses with add, remove and
// membership query, held in a single-port-read synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per operation: mode (add, remove, query; the
//   unused code acts as a query) and the key. rsp returns exactly one
//   transaction per request: found (key present before the operation),
//   overwrote_last (an add hit a full list and replaced the last entry) and
//   count (entries afterwards, low six bits).
//   The scan reads one entry a cycle from the entry memory. A remove moves
//   every later entry down one place through the same memory port after
//   the match.
//   One request is worked at a time; req.ready is high only while idle.
//   The response sits in an output register, so the next request is taken
//   while a response still waits. If rsp is stalled, the block holds a
//   finished result until the register frees and takes nothing new.
//   Reset clears the count and all control state; the memory is not
//   cleared, since no entry at or beyond the count is ever read.
// ----------------------------------------------------------------------------
module unique_address_list_top #(
	parameter int MAX_ENTRIES = ual_pkg::MAX_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ual_req_if.sink   req,
	ual_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]                  state_q;
	logic [ual_pkg::MODE_W-1:0]  mode_q;
	logic [ual_pkg::KEY_W-1:0]   key_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            idx_q;
	logic                        found_q;
	logic                        overwrote_q;

	// read pipeline: one entry in flight behind the issue index
	logic                        rd_valid_s1;
	logic [CNT_W-1:0]            rd_idx_s1;

	logic                        rsp_valid_q;
	logic                        rsp_found_q;
	logic                        rsp_overwrote_q;
	logic [ual_pkg::COUNT_W-1:0] rsp_count_q;

	logic                        hit;
	logic                        issue;
	logic                        full;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic [ual_pkg::KEY_W-1:0]   rd_data;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [ual_pkg::KEY_W-1:0]   wr_data;
	logic [CNT_W-1:0]            dst_idx;

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.found          = rsp_found_q;
	assign rsp.overwrote_last = rsp_overwrote_q;
	assign rsp.count          = rsp_count_q;

	assign full = (count_q == CNT_MAX);

	// first match stops the scan; later reads are not issued
	assign hit = (state_q == ST_SCAN) && rd_valid_s1 && (rd_data == key_q);

	// read the next live entry while scanning or shifting
	assign issue = (((state_q == ST_SCAN) && !hit) || (state_q == ST_SHIFT))
		&& (idx_q < count_q);

	assign rd_en   = issue;
	assign rd_addr = idx_q[IDX_W-1:0];
	assign dst_idx = rd_idx_s1 - CNT_W'(1);

	// write port: append/overwrite on add, move an entry down one place on shift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = dst_idx[IDX_W-1:0];
		wr_data = rd_data;
		if (state_q == ST_ADD) begin
			wr_en   = 1'b1;
			wr_addr = full ? IDX_LAST : count_q[IDX_W-1:0];
			wr_data = key_q;
		end else if ((state_q == ST_SHIFT) && rd_valid_s1) begin
			wr_en = 1'b1;
		end
	end

	ual_mem #(
		.DEPTH  (MAX_ENTRIES),
		.ADDR_W (IDX_W),
		.DATA_W (ual_pkg::KEY_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			key_q  <= req.key;
		end
		if (issue) begin
			rd_idx_s1 <= idx_q;
		end
		if ((state_q == ST_RESP) && (!rsp_valid_q || rsp.ready)) begin
			rsp_found_q     <= found_q;
			rsp_overwrote_q <= overwrote_q;
			rsp_count_q     <= ual_pkg::COUNT_W'(count_q);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			overwrote_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// load a finished result once the register frees; drop it once taken
			if ((state_q == ST_RESP) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						idx_q       <= '0;
						found_q     <= 1'b0;
						overwrote_q <= 1'b0;
						rd_valid_s1 <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						if (mode_q == ual_pkg::MODE_REMOVE) begin
							idx_q   <= rd_idx_s1 + CNT_W'(1);
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_RESP;
						end
					end else if (!issue && !rd_valid_s1) begin
						// scanned every live entry without a match
						state_q <= (mode_q == ual_pkg::MODE_ADD) ? ST_ADD : ST_RESP;
					end
				end
				ST_ADD: begin
					if (full) begin
						overwrote_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_RESP;
				end
				ST_SHIFT: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (!issue && !rd_valid_s1) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/ual_mem.sv
// ----------------------------------------------------------------------------
// ual_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ual_mem #(
	parameter int DEPTH  = ual_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_W = $clog2(ual_pkg::MAX_ENTRIES_DEF),
	parameter int DATA_W = ual_pkg::KEY_W
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> tb/sv/unique_address_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_address_list_checker
// Watches the request and response channels of the unique address list,
// keeps its own copy of the list, predicts each response and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module unique_address_list_checker #(
	parameter int MAX_ENTRIES = ual_pkg::MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ual_req_if   req,
	ual_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   overwrites,
	output int   peak_count
);

	typedef struct packed {
		logic                        found;
		logic                        overwrote_last;
		logic [ual_pkg::COUNT_W-1:0] count;
	} ual_result_t;

	logic [ual_pkg::KEY_W-1:0] addr_list[$];
	ual_result_t               result_q[$];

	int n_fail;
	int n_checked;
	int n_overwrites;
	int n_peak;

	task automatic report_mismatch(input string what, input int got, input int want);
		n_fail++;
		if (n_fail <= 40) begin
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	// Apply one operation to the list copy and return the response it causes.
	function automatic ual_result_t apply_op(input logic [ual_pkg::MODE_W-1:0] op,
		input logic [ual_pkg::KEY_W-1:0] addr);
		ual_result_t res;
		int          pos;
		pos = -1;
		foreach (addr_list[i]) begin
			if (pos < 0 && addr_list[i] == addr) begin
				pos = i;
			end
		end
		res.found          = (pos >= 0);
		res.overwrote_last = 1'b0;
		case (op)
		ual_pkg::MODE_ADD: begin
			if (pos < 0) begin
				if (addr_list.size() < MAX_ENTRIES) begin
					addr_list.push_back(addr);
				end else begin
					addr_list[MAX_ENTRIES-1] = addr;
					res.overwrote_last       = 1'b1;
				end
			end
		end
		ual_pkg::MODE_REMOVE: begin
			if (pos >= 0) begin
				addr_list.delete(pos);
			end
		end
		default: begin
		end
		endcase
		res.count = ual_pkg::COUNT_W'(addr_list.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ual_result_t want;
		if (!arst_n) begin
			addr_list.delete();
			result_q.delete();
		end else begin
			// Responses first: any response this edge belongs to an earlier request.
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (result_q.size() == 0) begin
					report_mismatch("response with nothing outstanding", 1, 0);
				end else begin
					want = result_q.pop_front();
					if (rsp.found !== want.found) begin
						report_mismatch("found", int'(rsp.found), int'(want.found));
					end
					if (rsp.overwrote_last !== want.overwrote_last) begin
						report_mismatch("overwrote_last", int'(rsp.overwrote_last),
							int'(want.overwrote_last));
					end
					if (rsp.count !== want.count) begin
						report_mismatch("count", int'(rsp.count), int'(want.count));
					end
					if (want.overwrote_last) begin
						n_overwrites++;
					end
					n_checked++;
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				result_q.push_back(apply_op(req.mode, req.key));
				if (addr_list.size() > n_peak) begin
					n_peak = addr_list.size();
				end
			end
		end
		fail_count <= n_fail;
		pending    <= result_q.size();
		checked    <= n_checked;
		overwrites <= n_overwrites;
		peak_count <= n_peak;
	end

endmodule

>>> tb/sv/unique_address_list_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_address_list_top_test
// Drives add, remove and query transactions into the unique address list
// with random gaps and stalls on both channels, and leaves prediction and
// comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module unique_address_list_top_test;

	localparam int MAX_ENTRIES  = ual_pkg::MAX_ENTRIES_DEF;
	// Watch well past the slowest request.
	localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 20;
	// Long receiver hold-off, well past the depth of the block's buffering.
	localparam int HOLD_CYCLES  = 300;
	// The spare mode code, which the block treats as a query.
	localparam logic [ual_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	ual_req_if req_ch ();
	ual_rsp_if rsp_ch ();

	int fail_count;
	int pending;
	int checked;
	int overwrites;
	int peak_count;

	// The first two are shared between the stimulus and the response sink.
	bit no_idle;
	bit hold_request;
	int n_sent;

	logic [ual_pkg::KEY_W-1:0] key_pool[64];

	unique_address_list_top #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	unique_address_list_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked),
		.overwrites(overwrites),
		.peak_count(peak_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: several times the slowest legal run.
	initial begin
		#4000000;
		$display("FAIL unique_address_list_top");
		$finish;
	end

	// Gap length in cycles: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly keys from a shared pool so that adds collide and removes hit;
	// a tenth are fresh random keys to toggle every bit.
	function automatic logic [ual_pkg::KEY_W-1:0] pick_key(input int pool_n);
		if ($urandom_range(0, 9) == 0) return $urandom();
		return key_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic [ual_pkg::MODE_W-1:0] pick_mode(input int add_pct,
		input int rem_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_pct) return ual_pkg::MODE_ADD;
		if (r < add_pct + rem_pct) return ual_pkg::MODE_REMOVE;
		if (r % 5 == 0) return MODE_UNUSED;
		return ual_pkg::MODE_QUERY;
	endfunction

	// Offer one transaction and hold it until accepted. Call and return at a
	// falling edge, so valid gets at most one assignment per time step.
	task automatic send_op(input logic [ual_pkg::MODE_W-1:0] op,
		input logic [ual_pkg::KEY_W-1:0] addr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= op;
		req_ch.key   <= addr;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic run_phase(input int add_pct, input int rem_pct, input int pool_n,
		input int n_items);
		repeat (n_items) send_op(pick_mode(add_pct, rem_pct), pick_key(pool_n));
	endtask

	// Response sink: random stalls, plus one long hold-off on request.
	initial begin : rsp_sink
		int stall_left;
		int gap;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				// Hold ready low for the whole stretch so the block backs up.
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					rsp_ch.ready <= 1'b1;
				end else begin
					rsp_ch.ready <= 1'b0;
					stall_left = gap - 1;
				end
			end
		end
	end

	initial begin : stimulus
		int ph;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode  = ual_pkg::MODE_QUERY;
		req_ch.key   = '0;
		no_idle      = 1'b0;
		hold_request = 1'b0;
		n_sent       = 0;
		foreach (key_pool[i]) begin
			key_pool[i] = $urandom();
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty list, both key extremes, repeat add, spare mode,
		// absent remove, and removal from the front and the back.
		send_op(ual_pkg::MODE_QUERY,  32'h0000_0000);
		send_op(ual_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
		send_op(ual_pkg::MODE_ADD,    32'h0000_0000);
		send_op(ual_pkg::MODE_ADD,    32'hFFFF_FFFF);
		send_op(ual_pkg::MODE_ADD,    32'h0000_0000);
		send_op(ual_pkg::MODE_QUERY,  32'hFFFF_FFFF);
		send_op(MODE_UNUSED,          32'h0000_0000);
		send_op(MODE_UNUSED,          32'h1234_5678);
		send_op(ual_pkg::MODE_ADD,    32'hA5A5_A5A5);
		send_op(ual_pkg::MODE_ADD,    32'h5A5A_5A5A);
		send_op(ual_pkg::MODE_REMOVE, 32'h1357_9BDF);
		send_op(ual_pkg::MODE_REMOVE, 32'h0000_0000);
		send_op(ual_pkg::MODE_QUERY,  32'h0000_0000);
		send_op(ual_pkg::MODE_REMOVE, 32'h5A5A_5A5A);
		send_op(ual_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
		send_op(ual_pkg::MODE_REMOVE, 32'hA5A5_A5A5);
		send_op(ual_pkg::MODE_QUERY,  32'hA5A5_A5A5);

		// Random: fill, churn at full (overwrites), drain, tight pool, mixed.
		// Run the cycle twice; the mixed phase goes without idling.
		for (ph = 0; ph < 10; ph++) begin
			no_idle = (ph % 5 == 4);
			// Stall the receiver while the sender keeps going.
			if (ph % 5 == 1) begin
				hold_request = 1'b1;
			end
			case (ph % 5)
			0: run_phase(80, 5, 48, 60);
			1: run_phase(60, 10, 64, 50);
			2: run_phase(15, 70, 64, 50);
			3: run_phase(40, 40, 6, 40);
			default: run_phase(45, 35, 40, 50);
			endcase
			// Pause the sender until every response is back.
			if (ph % 5 == 2) begin
				req_ch.valid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
		end
		no_idle = 1'b0;

		// Drop valid, drain the outstanding responses, then watch a while longer
		// for anything spurious.
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d requests and %0d checked responses.", n_sent, checked);
		$display("List peaked at %0d entries; %0d adds replaced the last entry.",
			peak_count, overwrites);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS unique_address_list_top");
		end else begin
			$display("FAIL unique_address_list_top");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ual_pkg.sv
hw/rtl/ual_if.sv
hw/rtl/ual_mem.sv
hw/rtl/unique_address_list_top.sv
tb/sv/unique_address_list_checker.sv
tb/sv/unique_address_list_top_test.sv
